@@ rtl/core/event_stream_timestamp_encoder_assert.svh @@
`ifndef EVENT_STREAM_TIMESTAMP_ENCODER_ASSERT_SVH
`define EVENT_STREAM_TIMESTAMP_ENCODER_ASSERT_SVH

// Assertion helpers: sampled on clk, off while arst_n is low.

// Condition that must hold in every cycle.
`define ESTE_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ESTE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/este_pkg.sv @@
package este_pkg;

	// Longest byte run of one event: two address bytes and four timestamp bytes.
	localparam int MAX_BYTES = 6;
	localparam int CNT_W = 3;
	localparam int QUEUE_DEPTH = 4;

	// data_format codes
	localparam logic [2:0] FMT_NONE  = 3'd0;
	localparam logic [2:0] FMT_DELTA = 3'd1;
	localparam logic [2:0] FMT_ABS2  = 3'd2;
	localparam logic [2:0] FMT_ABS3  = 3'd3;
	localparam logic [2:0] FMT_ABS4  = 3'd4;

	// Register byte address
	localparam logic [2:0] ADDR_DATA_FORMAT = 3'd0;

	localparam logic [7:0]  GROUP_MARK  = 8'h80;
	localparam logic [31:0] LIMIT_ONE   = 32'h0000_007F;
	localparam logic [31:0] LIMIT_TWO   = 32'h0000_3FFF;
	localparam logic [31:0] LIMIT_THREE = 32'h001F_FFFF;

	// One classified event: its bytes in send order and how many there are.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
	} este_desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} este_qstat_t;

endpackage

@@ rtl/core/event_stream_timestamp_encoder.sv @@
// Sensor event to byte-stream encoder.
// Input channel s_*: one transaction per event (16-bit address, 32-bit time).
// Output channel m_*: one byte per transaction; m_tlast marks the final byte
// of each event's run of 2 to 6 bytes.
// APB port: data_format register at byte address 0 (0 none, 1 delta varint,
// 2/3/4 absolute timestamp bytes; 5 to 7 act as none). Write it while idle.
// With the queue empty and the output register free, the first byte of an
// event is valid on m_* once the event has entered the queue and that byte
// has been loaded into the output register; then one byte per cycle while
// m_tready stays high. The event rate is set by the single-byte output
// register of the back end, which sends each event's 2 to 6 bytes in turn.
// A front end classifies each event and queues its bytes (QUEUE_DEPTH events);
// s_tready drops only when that queue is full, so input keeps flowing while
// the receiver stalls, and the output byte holds until taken.
// Reset clears the format register to 0, the delta reference time to 0 and
// empties the queue; no byte is pending after reset.
module event_stream_timestamp_encoder
	import este_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: event_address [15:0], event_time [47:16]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	// m_tdata: out_byte [7:0]; m_tlast: last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0]  fmt_q;
	logic        push;
	logic        pop;
	este_desc_t  wr_desc;
	este_desc_t  head;
	este_qstat_t qstat;

	// Register port: zero wait states; writes to other addresses are dropped.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_DATA_FORMAT) ? {29'd0, fmt_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_NONE;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_DATA_FORMAT) begin
			fmt_q <= pwdata[2:0];
		end
	end

	// Front: accept and classify one event into its byte run.
	este_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_format (fmt_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.qstat       (qstat),
		.push        (push),
		.desc        (wr_desc)
	);

	// Queue of classified events between the two sides.
	este_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (wr_desc),
		.pop     (pop),
		.rd_desc (head),
		.qstat   (qstat)
	);

	// Back: serialize the head event one byte per cycle while m_tready is high.
	este_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/core/este_front.sv @@
module este_front
	import este_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  data_format,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	input  este_qstat_t qstat,
	output logic        push,
	output este_desc_t  desc
);

	logic [15:0] addr;
	logic [31:0] t;
	logic [31:0] prev_time_q;
	logic [31:0] delta;
	logic [CNT_W-1:0] ts_n;
	logic [3:0][7:0] ts;

	assign addr     = s_tdata[15:0];
	assign t        = s_tdata[47:16];
	assign s_tready = !qstat.full;
	assign push     = s_tvalid && s_tready;
	assign delta    = t - prev_time_q;

	// Timestamp bytes, left aligned in send order.
	always_comb begin
		ts   = '0;
		ts_n = '0;
		case (data_format)
			FMT_DELTA: begin
				if (delta < LIMIT_ONE) begin
					ts_n  = 3'd1;
					ts[0] = GROUP_MARK | {1'b0, delta[6:0]};
				end else if (delta < LIMIT_TWO) begin
					ts_n  = 3'd2;
					ts[0] = {1'b0, delta[13:7]};
					ts[1] = GROUP_MARK | {1'b0, delta[6:0]};
				end else if (delta < LIMIT_THREE) begin
					ts_n  = 3'd3;
					ts[0] = {1'b0, delta[20:14]};
					ts[1] = {1'b0, delta[13:7]};
					ts[2] = GROUP_MARK | {1'b0, delta[6:0]};
				end else begin
					ts_n  = 3'd4;
					ts[0] = {1'b0, delta[27:21]};
					ts[1] = {1'b0, delta[20:14]};
					ts[2] = {1'b0, delta[13:7]};
					ts[3] = GROUP_MARK | {1'b0, delta[6:0]};
				end
			end
			FMT_ABS2: begin
				ts_n  = 3'd2;
				ts[0] = t[15:8];
				ts[1] = t[7:0];
			end
			FMT_ABS3: begin
				ts_n  = 3'd3;
				ts[0] = t[23:16];
				ts[1] = t[15:8];
				ts[2] = t[7:0];
			end
			FMT_ABS4: begin
				ts_n  = 3'd4;
				ts[0] = t[31:24];
				ts[1] = t[23:16];
				ts[2] = t[15:8];
				ts[3] = t[7:0];
			end
			default: begin
				ts_n = '0;
			end
		endcase
	end

	always_comb begin
		desc.bytes    = '0;
		desc.bytes[0] = addr[15:8] | GROUP_MARK;
		desc.bytes[1] = addr[7:0];
		desc.bytes[2] = ts[0];
		desc.bytes[3] = ts[1];
		desc.bytes[4] = ts[2];
		desc.bytes[5] = ts[3];
		desc.count    = ts_n + 3'd2;
	end

	// Advance the delta reference only on events sent in delta format.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
		end else if (push && data_format == FMT_DELTA) begin
			prev_time_q <= t;
		end
	end

endmodule

@@ rtl/core/este_queue.sv @@
module este_queue
	import este_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  este_desc_t  wr_desc,
	input  logic        pop,
	output este_desc_t  rd_desc,
	output este_qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	este_desc_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign qstat.full  = (cnt_q == CNT_W_Q'(DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rd_desc     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/core/este_back.sv @@
module este_back
	import este_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  este_desc_t  head,
	input  este_qstat_t qstat,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	logic [CNT_W-1:0] idx_q;
	logic m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic m_tlast_q;
	logic load;
	logic is_last;

	assign load     = !qstat.empty && (!m_tvalid_q || m_tready);
	assign is_last  = (idx_q == head.count - 3'd1);
	assign pop      = load && is_last;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
			idx_q      <= is_last ? '0 : idx_q + 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= head.bytes[idx_q];
			m_tlast_q <= is_last;
		end
	end

endmodule

@@ rtl/core/este_checker.sv @@
`include "event_stream_timestamp_encoder_assert.svh"

module este_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        pready,
	input logic [31:0] prdata
);

	// High while the next output byte opens a new event run.
	logic run_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_start_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			run_start_q <= m_tlast;
		end
	end

	`ESTE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")
	`ESTE_ASSERT_ALWAYS(a_run_head, !(m_tvalid && run_start_q) || (m_tdata[7] && !m_tlast), "run does not open with a marked address byte")
	`ESTE_ASSERT_NEXT(a_second_not_marked_last, m_tvalid && m_tready && run_start_q, !m_tvalid || !run_start_q, "run ended after one byte")
	`ESTE_ASSERT_ALWAYS(a_apb_rd, pready && prdata[31:3] == 29'd0, "register port returned bad status")

endmodule

bind event_stream_timestamp_encoder este_checker u_este_checker (.*);
